// ===== design/fwc_pkg.sv =====
// fwc_pkg: shared types, key reset values and the round mixing function
// for the feistel word cipher; no dependencies
package fwc_pkg;

    localparam int HALF_W     = 16;
    localparam int KEY_SLOTS  = 8;
    localparam int KEY_IDX_W  = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int ROT_AMOUNT = 5;
    localparam int SHR_AMOUNT = 3;

    typedef logic [HALF_W-1:0] half_t;

    typedef enum logic {
        DIR_ENCRYPT = 1'b0,
        DIR_DECRYPT = 1'b1
    } dir_t;

    // word travelling down the chain of round cells
    typedef struct packed {
        dir_t  kind;
        half_t left;
        half_t right;
    } fwc_word_t;

    localparam half_t KEY_RESET [KEY_SLOTS] = '{
        16'h1234, 16'hBEEF, 16'hCAFE, 16'h0BAD,
        16'hFACE, 16'hDEAD, 16'h0000, 16'h0000
    };

    function automatic half_t mix16(input half_t v, input half_t k);
        half_t t;
        t = v + k;
        t = t ^ {t[HALF_W-ROT_AMOUNT-1:0], t[HALF_W-1:HALF_W-ROT_AMOUNT]};
        t = t ^ (t >> SHR_AMOUNT);
        return t;
    endfunction

endpackage

// ===== design/fwc_round_cell.sv =====
// fwc_round_cell: one feistel round with its own pipeline register and
// valid bit; depends on fwc_pkg
module fwc_round_cell
    import fwc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      up_valid,
    output logic      up_ready,
    input  fwc_word_t up_data,
    input  half_t     key_enc,
    input  half_t     key_dec,
    output logic      dn_valid,
    input  logic      dn_ready,
    output fwc_word_t dn_data
);

    logic      valid_reg;
    fwc_word_t data_reg;
    fwc_word_t data_next;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb begin
        data_next.kind = up_data.kind;
        if (up_data.kind == DIR_DECRYPT) begin
            data_next.left  = up_data.right ^ mix16(up_data.left, key_dec);
            data_next.right = up_data.left;
        end else begin
            data_next.left  = up_data.right;
            data_next.right = up_data.left ^ mix16(up_data.right, key_enc);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_valid && up_ready) begin
            data_reg <= data_next;
        end
    end

`ifndef ASSERT_OFF
    // a stalled word must stay put in this cell
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !dn_ready |=> valid_reg && $stable(data_reg))
        else $error("round cell lost or changed a stalled word");

    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        up_valid && up_ready |=> valid_reg)
        else $error("round cell dropped an accepted word");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg |-> up_ready)
        else $error("empty round cell refused a transfer");
`endif

endmodule

// ===== design/feistel_word_cipher.sv =====
// feistel_word_cipher: top level, key registers and the chain of round cells
// depends on fwc_pkg and fwc_round_cell
//
// Feistel cipher on 32-bit words with 16-bit halves. Each round is one cell
// of a pipeline chain, so a word passes through the register of every cell,
// and a new word is taken in every cycle; the ready path ripples back through
// the cells, so a stalled output only blocks input once every cell is full.
// s_kind selects encryption (keys ascending) or decryption (keys descending).
// Round keys are written through cfg_wr_en/cfg_index/cfg_wr_data; indexes past
// the eighth key are ignored. Keys should only change while the chain is empty.
module feistel_word_cipher
    import fwc_pkg::*;
#(
    parameter int ROUND_COUNT = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HALF_W-1:0]    cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_kind,
    input  logic [2*HALF_W-1:0]  s_data_word,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2*HALF_W-1:0]  m_result_word
);

    half_t key_reg  [KEY_SLOTS];
    half_t key_next [KEY_SLOTS];

    logic      stage_valid [ROUND_COUNT+1];
    logic      stage_ready [ROUND_COUNT+1];
    fwc_word_t stage_data  [ROUND_COUNT+1];

    always_comb begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
            key_next[i] = key_reg[i];
        end
        if (cfg_wr_en && (cfg_index < CFG_IDX_W'(KEY_SLOTS))) begin
            key_next[cfg_index[KEY_IDX_W-1:0]] = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
                key_reg[i] <= KEY_RESET[i];
            end
        end else begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
                key_reg[i] <= key_next[i];
            end
        end
    end

    assign stage_valid[0]      = s_valid;
    assign s_ready             = stage_ready[0];
    assign stage_data[0].kind  = dir_t'(s_kind);
    assign stage_data[0].left  = s_data_word[2*HALF_W-1:HALF_W];
    assign stage_data[0].right = s_data_word[HALF_W-1:0];

    // cell i runs round i going forwards and round ROUND_COUNT-1-i going back
    for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_round
        fwc_round_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .up_valid (stage_valid[i]),
            .up_ready (stage_ready[i]),
            .up_data  (stage_data[i]),
            .key_enc  (key_reg[i]),
            .key_dec  (key_reg[ROUND_COUNT-1-i]),
            .dn_valid (stage_valid[i+1]),
            .dn_ready (stage_ready[i+1]),
            .dn_data  (stage_data[i+1])
        );
    end

    assign stage_ready[ROUND_COUNT] = m_ready;
    assign m_valid       = stage_valid[ROUND_COUNT];
    assign m_result_word = {stage_data[ROUND_COUNT].left, stage_data[ROUND_COUNT].right};

`ifndef ASSERT_OFF
    // with the last cell empty the whole chain can move, so input is open
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input refused although output stage is empty");

    a_empty_after_reset: assert property (@(posedge aclk)
        !$past(aresetn) |-> !m_valid)
        else $error("result shown straight after reset");

    a_key_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en && cfg_index == CFG_IDX_W'(0) |=> key_reg[0] == $past(cfg_wr_data))
        else $error("key write not taken");
`endif

endmodule

// ===== dv/feistel_word_cipher_test.sv =====
// feistel_word_cipher_test: self-checking bench for the feistel word cipher,
// random and directed words against an in-bench round model with key writes
// depends on fwc_pkg and feistel_word_cipher
module feistel_word_cipher_test;
    import fwc_pkg::*;

    localparam int ROUND_COUNT   = 6;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_WORDS   = 250;
    localparam int LONG_HOLD     = 120;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct {
        dir_t        kind;
        logic [31:0] word;
    } cipher_req_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [HALF_W-1:0]    cfg_wr_data = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic                 s_kind      = 1'b0;
    logic [2*HALF_W-1:0]  s_data_word = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [2*HALF_W-1:0]  m_result_word;

    half_t       key_copy [KEY_SLOTS];
    cipher_req_t pending_words [$];
    logic [31:0] expected_results [$];
    bit          idle_on;
    int          send_gap;
    int          recv_wait;
    int          long_hold;
    int          recv_count;
    int          error_count;
    int          cycle_count;
    cipher_req_t next_req;

    feistel_word_cipher #(
        .ROUND_COUNT(ROUND_COUNT)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_data_word  (s_data_word),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_result_word(m_result_word)
    );

    always #5 aclk = ~aclk;

    function automatic half_t round_mix(input half_t v, input half_t k);
        half_t s;
        s = v + k;
        s = s ^ ((s << 5) | (s >> 11));
        s = s ^ (s >> 3);
        return s;
    endfunction

    function automatic logic [31:0] cipher_word(input dir_t dir, input logic [31:0] word);
        half_t l;
        half_t r;
        half_t t;
        l = word[31:16];
        r = word[15:0];
        if (dir == DIR_ENCRYPT) begin
            for (int i = 0; i < ROUND_COUNT; i++) begin
                t = l ^ round_mix(r, key_copy[i]);
                l = r;
                r = t;
            end
        end else begin
            // keys taken in descending order, halves swapped the other way
            for (int i = ROUND_COUNT - 1; i >= 0; i--) begin
                t = r ^ round_mix(l, key_copy[i]);
                r = l;
                l = t;
            end
        end
        return {l, r};
    endfunction

    // one write per clock; caller drops the enable afterwards
    task automatic write_key(input int idx, input half_t value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx[CFG_IDX_W-1:0];
        cfg_wr_data <= value;
        if (idx < KEY_SLOTS)
            key_copy[idx] = value;
    endtask

    task automatic end_writes();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_word(input dir_t kind, input logic [31:0] word);
        cipher_req_t req;
        req.kind = kind;
        req.word = word;
        pending_words.insert(pending_words.size(), req);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (pending_words.size() != 0 || s_valid || expected_results.size() != 0)
            @(negedge aclk);
    endtask

    // driver: offers pending words, logs an expectation on every transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid     <= 1'b0;
            s_kind      <= 1'b0;
            s_data_word <= '0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready)
                expected_results.insert(expected_results.size(),
                                        cipher_word(dir_t'(s_kind), s_data_word));
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    next_req = pending_words.pop_front();
                    s_valid     <= 1'b1;
                    s_kind      <= next_req.kind;
                    s_data_word <= next_req.word;
                    send_gap = idle_on ? $urandom_range(4, 0) : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result transfer against the oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_wait  = 0;
            long_hold  = 0;
            recv_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result_word %h", m_result_word);
                    error_count++;
                end else begin
                    logic [31:0] want;
                    want = expected_results.pop_front();
                    if (m_result_word !== want) begin
                        $error("result_word mismatch: expected %h, actual %h",
                               want, m_result_word);
                        error_count++;
                    end
                end
                recv_count++;
                // long back-pressure so the chain fills and input stalls
                if (recv_count % 500 == 250)
                    long_hold = LONG_HOLD;
                recv_wait = idle_on ? $urandom_range(4, 0) : 0;
            end
            if (long_hold > 0) begin
                long_hold--;
                m_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [31:0] edge_words [8];
        edge_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                       32'h0000_FFFF, 32'hFFFF_0000, 32'hAAAA_AAAA, 32'h5555_5555};
        key_copy = '{16'h1234, 16'hBEEF, 16'hCAFE, 16'h0BAD,
                     16'hFACE, 16'hDEAD, 16'h0000, 16'h0000};
        error_count = 0;
        cycle_count = 0;
        idle_on     = 1'b1;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // extreme words in both directions under the reset keys
        foreach (edge_words[i]) begin
            queue_word(DIR_ENCRYPT, edge_words[i]);
            queue_word(DIR_DECRYPT, edge_words[i]);
        end
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            for (int k = 0; k < KEY_SLOTS; k++) begin
                case (p)
                    0:       write_key(k, 16'h0000);
                    1:       write_key(k, 16'hFFFF);
                    default: write_key(k, half_t'($urandom));
                endcase
            end
            // writes past the last key must leave every key untouched
            if (p == 2) begin
                write_key(KEY_SLOTS, half_t'($urandom));
                write_key(2**CFG_IDX_W - 1, half_t'($urandom));
            end else if (p > 2) begin
                write_key($urandom_range(2**CFG_IDX_W - 1, KEY_SLOTS), half_t'($urandom));
            end
            end_writes();
            idle_on = (p % 3 != 1);

            for (int n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(15, 0) == 0)
                    queue_word(dir_t'($urandom_range(1, 0)), edge_words[$urandom_range(7, 0)]);
                else
                    queue_word(dir_t'($urandom_range(1, 0)), $urandom);
            end
            wait_drained();
        end

        repeat (4 * ROUND_COUNT) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $error("%0d result_word expectations left over", expected_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/fwc_pkg.sv
design/fwc_round_cell.sv
design/feistel_word_cipher.sv
dv/feistel_word_cipher_test.sv
